[sv/rau_pkg.sv]
package rau_pkg;

	// Arithmetic operation codes
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Operand pairing for the shared multiplier
	typedef enum logic [1:0] {
		MS_NUM   = 2'd0,
		MS_CROSS = 2'd1,
		MS_DEN   = 2'd2
	} mul_sel_t;

	// Odd primes handled by the constant divider
	typedef enum logic [1:0] {
		PR_3 = 2'd0,
		PR_5 = 2'd1,
		PR_7 = 2'd2
	} prime_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_MUL0  = 4'd1,
		ST_MUL1  = 4'd2,
		ST_MUL2  = 4'd3,
		ST_SUM   = 4'd4,
		ST_ABS   = 4'd5,
		ST_CHKZ  = 4'd6,
		ST_TWO   = 4'd7,
		ST_DLOAD = 4'd8,
		ST_DSTEP = 4'd9,
		ST_DCHK  = 4'd10,
		ST_FIN   = 4'd11
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum;
		logic     abs_en;
		logic     shift2;
		logic     div_load;
		logic     div_step;
		logic     div_commit;
		prime_t   prime;
		logic     out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic both_zero;
		logic both_even;
		logic rem_zero;
	} status_t;

	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 32;
	localparam int DIGIT_W   = 8;

	function automatic logic [2:0] prime_value(input prime_t p);
		logic [2:0] v;
		case (p)
			PR_3:    v = 3'd3;
			PR_5:    v = 3'd5;
			PR_7:    v = 3'd7;
			default: v = 3'd7;
		endcase
		return v;
	endfunction

	// Long division of one byte by a small constant, remainder carried in and out.
	// Returns {quotient byte, remainder}.
	function automatic logic [DIGIT_W+2:0] div_byte(input logic [2:0] rem_in,
			input logic [DIGIT_W-1:0] dig, input logic [2:0] p);
		logic [3:0]         t;
		logic [2:0]         r;
		logic [DIGIT_W-1:0] q;
		r = rem_in;
		q = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {r, dig[i]};
			if (t >= {1'b0, p}) begin
				q[i] = 1'b1;
				t = t - {1'b0, p};
			end
			r = t[2:0];
		end
		return {q, r};
	endfunction

endpackage

[sv/rau_sdiv.sv]
module rau_sdiv #(
	parameter int DW = 40
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [DW-1:0] dividend,
	input  logic [2:0]    divisor,
	output logic [DW-1:0] quotient,
	output logic          rem_zero
);
	import rau_pkg::*;

	logic [DW-1:0]        sh_q;
	logic [2:0]           rem_q;
	logic [DIGIT_W+2:0]   dig_res;

	// Divide the top byte by the prime
	assign dig_res = div_byte(rem_q, sh_q[DW-1 -: DIGIT_W], divisor);

	// Shift dividend bytes out at the top, quotient bytes in at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= dividend;
			rem_q <= 3'd0;
		end else if (step) begin
			sh_q  <= {sh_q[DW-DIGIT_W-1:0], dig_res[DIGIT_W+2:3]};
			rem_q <= dig_res[2:0];
		end
	end

	assign quotient = sh_q;
	assign rem_zero = (rem_q == 3'd0);

endmodule

[sv/rau_dp.sv]
module rau_dp #(
	parameter int W = 16
) (
	input  logic                              clk,
	input  rau_pkg::cmd_t                     cmd,
	output rau_pkg::status_t                  status,
	input  rau_pkg::op_t                      operation,
	input  logic signed [W-1:0]               left_num,
	input  logic signed [W-1:0]               left_den,
	input  logic signed [W-1:0]               right_num,
	input  logic signed [W-1:0]               right_den,
	output logic signed [rau_pkg::NUM_OUT_W-1:0] result_num,
	output logic signed [rau_pkg::DEN_OUT_W-1:0] result_den,
	output logic                              zero_denominator
);
	import rau_pkg::*;

	localparam int PW   = 2 * W;
	localparam int SW   = PW + 1;
	localparam int NUMW = (SW > 64) ? 64 : SW;
	localparam int MW   = NUMW;
	localparam int DW   = ((MW + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;

	op_t                  op_q;
	logic signed [W-1:0]  ln_q, ld_q, rn_q, rd_q;
	logic signed [W-1:0]  mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] p0_q, p1_q, den_q;
	logic signed [SW-1:0] sum_w;
	logic signed [NUMW-1:0] sat_w;
	logic signed [NUMW-1:0] num_q;
	logic                 nsign_q, dsign_q;
	logic [MW-1:0]        nmag_q, dmag_q;
	logic [MW-1:0]        nval, dval;
	logic [DW-1:0]        nquo, dquo;
	logic                 nrz, drz;
	logic [2:0]           pval;

	// Capture operands on accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			ln_q <= left_num;
			ld_q <= left_den;
			rn_q <= right_num;
			rd_q <= right_den;
		end
	end

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MS_CROSS: begin
				mul_a = rn_q;
				mul_b = ld_q;
			end
			MS_DEN: begin
				mul_a = ld_q;
				mul_b = (op_q == OP_DIV) ? rn_q : rd_q;
			end
			default: begin
				mul_a = ln_q;
				mul_b = (op_q == OP_MUL) ? rn_q : rd_q;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_CROSS: p1_q  <= prod;
				MS_DEN:   den_q <= prod;
				default:  p0_q  <= prod;
			endcase
		end
	end

	// Combine the cross products
	always_comb begin
		case (op_q)
			OP_ADD:  sum_w = SW'(p0_q) + SW'(p1_q);
			OP_SUB:  sum_w = SW'(p0_q) - SW'(p1_q);
			default: sum_w = SW'(p0_q);
		endcase
	end

	// Saturate to the 64-bit signed range when the sum can exceed it
	generate
		if (SW > NUMW) begin : g_sat
			always_comb begin
				if (sum_w[SW-1] != sum_w[NUMW-1]) begin
					sat_w = sum_w[SW-1] ? {1'b1, {(NUMW-1){1'b0}}}
					                    : {1'b0, {(NUMW-1){1'b1}}};
				end else begin
					sat_w = sum_w[NUMW-1:0];
				end
			end
		end else begin : g_nosat
			assign sat_w = NUMW'(sum_w);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			num_q <= sat_w;
		end
	end

	// Constant dividers for numerator and denominator magnitudes
	assign pval = prime_value(cmd.prime);

	rau_sdiv #(.DW(DW)) u_ndiv (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (DW'(nmag_q)),
		.divisor  (pval),
		.quotient (nquo),
		.rem_zero (nrz)
	);

	rau_sdiv #(.DW(DW)) u_ddiv (
		.clk      (clk),
		.load     (cmd.div_load),
		.step     (cmd.div_step),
		.dividend (DW'(dmag_q)),
		.divisor  (pval),
		.quotient (dquo),
		.rem_zero (drz)
	);

	// Split into sign and magnitude, then strip factors
	always_ff @(posedge clk) begin
		if (cmd.abs_en) begin
			nsign_q <= num_q[NUMW-1];
			dsign_q <= den_q[PW-1];
			nmag_q  <= num_q[NUMW-1] ? MW'($unsigned(-num_q)) : MW'($unsigned(num_q));
			dmag_q  <= den_q[PW-1] ? MW'($unsigned(-den_q)) : MW'($unsigned(den_q));
		end else if (cmd.shift2) begin
			nmag_q <= nmag_q >> 1;
			dmag_q <= dmag_q >> 1;
		end else if (cmd.div_commit) begin
			nmag_q <= nquo[MW-1:0];
			dmag_q <= dquo[MW-1:0];
		end
	end

	assign status.both_zero = (nmag_q == '0) && (dmag_q == '0);
	assign status.both_even = !nmag_q[0] && !dmag_q[0];
	assign status.rem_zero  = nrz && drz;

	// Restore signs and register the result
	assign nval = nsign_q ? (~nmag_q + MW'(1)) : nmag_q;
	assign dval = dsign_q ? (~dmag_q + MW'(1)) : dmag_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_num       <= NUM_OUT_W'($signed(nval));
			result_den       <= DEN_OUT_W'($signed(dval));
			zero_denominator <= (dmag_q == '0);
		end
	end

endmodule

[sv/rau_ctrl.sv]
module rau_ctrl #(
	parameter int CHUNKS = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output rau_pkg::cmd_t    cmd,
	input  rau_pkg::status_t status
);
	import rau_pkg::*;

	localparam int CNTW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	state_t          state_q, state_d;
	prime_t          prime_q;
	logic [CNTW-1:0] cnt_q;
	logic            cnt_last;

	assign cnt_last = (cnt_q == CNTW'(CHUNKS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_MUL0;
			ST_MUL0:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_ABS;
			ST_ABS:   state_d = ST_CHKZ;
			ST_CHKZ:  state_d = status.both_zero ? ST_FIN : ST_TWO;
			ST_TWO:   if (!status.both_even) state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DSTEP;
			ST_DSTEP: if (cnt_last) state_d = ST_DCHK;
			ST_DCHK: begin
				if (status.rem_zero || prime_q != PR_7) begin
					state_d = ST_DLOAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd            = '0;
		cmd.mul_sel    = MS_NUM;
		cmd.prime      = prime_q;
		case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_MUL0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_NUM;
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_CROSS;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DEN;
			end
			ST_SUM:   cmd.sum = 1'b1;
			ST_ABS:   cmd.abs_en = 1'b1;
			ST_TWO:   cmd.shift2 = status.both_even;
			ST_DLOAD: cmd.div_load = 1'b1;
			ST_DSTEP: cmd.div_step = 1'b1;
			ST_DCHK:  cmd.div_commit = status.rem_zero;
			ST_FIN:   cmd.out_load = 1'b1;
			default:  cmd.load = 1'b0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// State, prime index and digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prime_q <= PR_3;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHKZ) begin
				prime_q <= PR_3;
			end else if (state_q == ST_DCHK && !status.rem_zero) begin
				case (prime_q)
					PR_3:    prime_q <= PR_5;
					PR_5:    prime_q <= PR_7;
					default: prime_q <= PR_7;
				endcase
			end
			if (state_q == ST_DLOAD) begin
				cnt_q <= '0;
			end else if (state_q == ST_DSTEP) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

endmodule

[sv/rational_arith_unit.sv]
// Sequence: the three products, the sum, the sign split and a zero check; when both raw
// values are zero the result is loaded at once, otherwise factors of two are shifted out and
// the primes 3, 5 and 7 are divided out over CHUNKS = ceil((2*OPERAND_WIDTH+1)/8) bytes, capped at 8.
// The constant dividers take one byte-wide step per cycle.
// One item at a time: busy drops in the cycle done is shown, and a new start is taken then.
// Reset is asynchronous, active low, and clears the controller and done; the receiver cannot stall.
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  rau_pkg::op_t                         operation,
	input  logic signed [OPERAND_WIDTH-1:0]      left_num,
	input  logic signed [OPERAND_WIDTH-1:0]      left_den,
	input  logic signed [OPERAND_WIDTH-1:0]      right_num,
	input  logic signed [OPERAND_WIDTH-1:0]      right_den,
	output logic                                 done,
	output logic signed [rau_pkg::NUM_OUT_W-1:0] result_num,
	output logic signed [rau_pkg::DEN_OUT_W-1:0] result_den,
	output logic                                 zero_denominator
);
	import rau_pkg::*;

	localparam int SW     = 2 * OPERAND_WIDTH + 1;
	localparam int NUMW   = (SW > 64) ? 64 : SW;
	localparam int CHUNKS = (NUMW + DIGIT_W - 1) / DIGIT_W;

	cmd_t    cmd;
	status_t status;
	logic    done_q;

	rau_ctrl #(.CHUNKS(CHUNKS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	rau_dp #(.W(OPERAND_WIDTH)) u_dp (
		.clk              (clk),
		.cmd              (cmd),
		.status           (status),
		.operation        (operation),
		.left_num         (left_num),
		.left_den         (left_den),
		.right_num        (right_num),
		.right_den        (right_den),
		.result_num       (result_num),
		.result_den       (result_den),
		.zero_denominator (zero_denominator)
	);

	// Mark the result transaction: done is registered from the output load command, so it rises with the new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_load;
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");
`endif

endmodule
